### sv/ffea_pkg.sv
// Package for the first-fit extent allocator.
// Holds payload types, status codes, the sequencer state type and sizing constants.
// No dependencies.
package ffea_pkg;

  localparam int unsigned PoolBytes      = 1048576;
  localparam int unsigned HeaderBytes    = 16;
  localparam int unsigned MaxFreeExtents = 64;
  localparam int unsigned MaxLiveBlocks  = 64;
  localparam int unsigned Alignment      = 16;

  localparam int unsigned OffW = 20;
  localparam int unsigned LenW = 21;

  typedef enum logic [0:0] {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_NOT_LIVE = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    func_e             func;
    logic [LenW-1:0]   request_size;
    logic [OffW-1:0]   release_offset;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [OffW-1:0]   data_offset;
    logic [LenW-1:0]   granted_size;
    logic [LenW-1:0]   bytes_in_use;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FSCAN,
    S_LSCAN,
    S_ALLOC_UPD,
    S_DROP,
    S_FIND,
    S_FLOOK,
    S_MERGE,
    S_INSERT,
    S_DONE
  } state_e;

endpackage

### sv/first_fit_extent_allocator.sv
// First-fit extent allocator: one request at a time over a sequencer that walks the tables.
// An allocate walks the free table, then the live table; a free walks the live table, then
// the free table. Either may then shift free entries down, and a free may ripple them up.
// The table walks go one entry per cycle. A new request is taken only after the response
// has been accepted.
// Reset leaves one free extent covering the pool and no live blocks; no clearing pass.
// Depends on ffea_pkg.
module first_fit_extent_allocator
  import ffea_pkg::*;
#(
  parameter int unsigned POOL_BYTES       = PoolBytes,
  parameter int unsigned HEADER_BYTES     = HeaderBytes,
  parameter int unsigned MAX_FREE_EXTENTS = MaxFreeExtents,
  parameter int unsigned MAX_LIVE_BLOCKS  = MaxLiveBlocks
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  localparam int unsigned FW = $clog2(MAX_FREE_EXTENTS);
  localparam int unsigned LW = $clog2(MAX_LIVE_BLOCKS);
  localparam int unsigned CW = FW + 1;
  localparam int unsigned SW = LW + 1;
  localparam int unsigned AW = LenW + 2;
  localparam logic [AW-1:0] Hdr = AW'(HEADER_BYTES);
  localparam logic [AW-1:0] Aln = AW'(Alignment);
  localparam logic [CW-1:0] FMax = CW'(MAX_FREE_EXTENTS);
  localparam logic [SW-1:0] LMax = SW'(MAX_LIVE_BLOCKS);

  logic [OffW-1:0] fs_mem [MAX_FREE_EXTENTS];
  logic [LenW-1:0] fl_mem [MAX_FREE_EXTENTS];
  logic [OffW-1:0] ls_mem [MAX_LIVE_BLOCKS];
  logic [LenW-1:0] ll_mem [MAX_LIVE_BLOCKS];
  logic [MAX_LIVE_BLOCKS-1:0] lv_q, lv_d;

  state_e state_q, state_d;
  req_t req_q, req_d;
  logic [CW-1:0] fcnt_q, fcnt_d, fi_q, fi_d, pos_q, pos_d;
  logic [SW-1:0] li_q, li_d;
  logic [LW-1:0] slot_q, slot_d;
  logic [OffW-1:0] hdr_q, hdr_d, ps_q, ps_d, ns_q, ns_d;
  logic [LenW-1:0] len_q, len_d, pl_q, pl_d, nl_q, nl_d;
  logic [AW-1:0] need_q, need_d;
  logic [LenW-1:0] use_q, use_d;
  rsp_t out_q, out_d;
  logic seeded_q, seeded_d;
  logic [OffW-1:0] hold_s_q, hold_s_d;
  logic [LenW-1:0] hold_l_q, hold_l_d;

  logic fwe;
  logic [FW-1:0] fwa;
  logic [OffW-1:0] fws;
  logic [LenW-1:0] fwl;
  logic lwe;
  logic [LenW-1:0] lwl;

  logic [FW-1:0] fidx;
  logic [FW-1:0] rd_addr_q, rd_addr_d;
  logic [OffW-1:0] fs_rd_q, ls_rd_q;
  logic [LenW-1:0] fl_rd_q, ll_rd_q;
  logic [OffW-1:0] fs_r;
  logic [LenW-1:0] fl_r;
  logic [AW-1:0] sum_a, sum_b, sum;
  logic adj_next, adj_prev;

  // Entry zero reads as the reset extent until the first write to it.
  assign fidx = fi_q[FW-1:0];
  always_comb begin
    if (rd_addr_q == '0 && !seeded_q) begin
      fs_r = '0;
      fl_r = LenW'(POOL_BYTES - HEADER_BYTES);
    end else begin
      fs_r = fs_rd_q;
      fl_r = fl_rd_q;
    end
  end

  assign sum = sum_a + sum_b;
  assign rd_addr_d = (state_d == S_DROP) ? FW'(fi_d + CW'(1)) : fi_d[FW-1:0];
  assign seeded_d = seeded_q | (fwe && fwa == '0);

  always_ff @(posedge clk_i) begin
    if (fwe) begin
      fs_mem[fwa] <= fws;
      fl_mem[fwa] <= fwl;
    end
    if (lwe) begin
      ls_mem[slot_q] <= hdr_q;
      ll_mem[slot_q] <= lwl;
    end
    fs_rd_q   <= fs_mem[rd_addr_d];
    fl_rd_q   <= fl_mem[rd_addr_d];
    ls_rd_q   <= ls_mem[li_d[LW-1:0]];
    ll_rd_q   <= ll_mem[li_d[LW-1:0]];
    rd_addr_q <= rd_addr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fcnt_q   <= CW'(1);
      lv_q     <= '0;
      use_q    <= '0;
      seeded_q <= 1'b0;
      out_q    <= '0;
    end else begin
      state_q  <= state_d;
      fcnt_q   <= fcnt_d;
      lv_q     <= lv_d;
      use_q    <= use_d;
      out_q    <= out_d;
      seeded_q <= seeded_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; fi_q <= fi_d; pos_q <= pos_d; li_q <= li_d; slot_q <= slot_d;
    hdr_q <= hdr_d; len_q <= len_d; need_q <= need_d;
    ps_q <= ps_d; pl_q <= pl_d; ns_q <= ns_d; nl_q <= nl_d;
    hold_s_q <= hold_s_d; hold_l_q <= hold_l_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_DONE);
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q; req_d = req_q; fcnt_d = fcnt_q; fi_d = fi_q; pos_d = pos_q;
    li_d = li_q; slot_d = slot_q; hdr_d = hdr_q; len_d = len_q; need_d = need_q;
    ps_d = ps_q; pl_d = pl_q; ns_d = ns_q; nl_d = nl_q;
    hold_s_d = hold_s_q; hold_l_d = hold_l_q;
    lv_d = lv_q; use_d = use_q; out_d = out_q;
    fwe = 1'b0; fwa = fidx; fws = fs_r; fwl = fl_r; lwe = 1'b0; lwl = len_q;
    sum_a = '0; sum_b = '0;
    adj_next = 1'b0; adj_prev = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = in_data_i;
          fi_d = '0;
          li_d = '0;
          out_d = '0;
          out_d.bytes_in_use = use_q;
          sum_a = AW'(in_data_i.request_size);
          sum_b = Aln - AW'(1);
          need_d = sum & ~(Aln - AW'(1));
          if (need_d < Aln) begin
            need_d = Aln;
          end
          state_d = (in_data_i.func == FUNC_ALLOC) ? S_FSCAN : S_LSCAN;
        end
      end
      S_FSCAN: begin
        if (fi_q >= fcnt_q) begin
          out_d.status = ST_NO_FIT;
          state_d = S_DONE;
        end else if (AW'(fl_r) >= need_q) begin
          pos_d = fi_q; hdr_d = fs_r; len_d = fl_r;
          state_d = S_LSCAN;
        end else begin
          fi_d = fi_q + CW'(1);
        end
      end
      S_LSCAN: begin
        if (li_q >= LMax) begin
          out_d.status = (req_q.func == FUNC_ALLOC) ? ST_FULL : ST_NOT_LIVE;
          state_d = S_DONE;
        end else if (req_q.func == FUNC_ALLOC) begin
          if (!lv_q[li_q[LW-1:0]]) begin
            slot_d = li_q[LW-1:0];
            fi_d = pos_q;
            state_d = S_ALLOC_UPD;
          end else begin
            li_d = li_q + SW'(1);
          end
        end else begin
          sum_a = AW'(ls_rd_q);
          sum_b = Hdr;
          if (lv_q[li_q[LW-1:0]] && sum == AW'(req_q.release_offset)) begin
            slot_d = li_q[LW-1:0];
            hdr_d = ls_rd_q;
            len_d = ll_rd_q;
            fi_d = '0;
            state_d = S_FIND;
          end else begin
            li_d = li_q + SW'(1);
          end
        end
      end
      S_ALLOC_UPD: begin
        sum_a = need_q + Hdr + Aln;
        sum_b = '0;
        lv_d[slot_q] = 1'b1;
        if (AW'(len_q) >= sum) begin
          fwe = 1'b1;
          fws = hdr_q + OffW'(HEADER_BYTES) + OffW'(need_q);
          fwl = len_q - LenW'(need_q) - LenW'(HEADER_BYTES);
          len_d = LenW'(need_q);
          state_d = S_DONE;
        end else begin
          fcnt_d = fcnt_q - CW'(1);
          fi_d = pos_q;
          state_d = S_DROP;
        end
        lwe = 1'b1;
        lwl = len_d;
        out_d.status = ST_OK;
        out_d.data_offset = hdr_q + OffW'(HEADER_BYTES);
        out_d.granted_size = len_d;
        use_d = use_q + len_d;
        out_d.bytes_in_use = use_d;
      end
      S_DROP: begin
        // Shift entries above the dropped one down by one.
        if (fi_q + CW'(1) > fcnt_q) begin
          state_d = S_DONE;
        end else begin
          fwe = 1'b1;
          fwa = fidx;
          fws = fs_r;
          fwl = fl_r;
          fi_d = fi_q + CW'(1);
        end
      end
      S_FIND: begin
        if (fi_q >= fcnt_q || fs_r > hdr_q) begin
          pos_d = fi_q;
          ns_d = fs_r; nl_d = fl_r;
          fi_d = fi_q - CW'(1);
          state_d = S_FLOOK;
        end else begin
          fi_d = fi_q + CW'(1);
        end
      end
      S_FLOOK: begin
        ps_d = fs_r; pl_d = fl_r;
        fi_d = pos_q;
        state_d = S_MERGE;
      end
      S_MERGE: begin
        adj_next = (pos_q < fcnt_q) &&
                   (AW'(hdr_q) + Hdr + AW'(len_q) == AW'(ns_q));
        adj_prev = (pos_q != '0) &&
                   (AW'(ps_q) + Hdr + AW'(pl_q) == AW'(hdr_q));
        if (!adj_next && !adj_prev && fcnt_q >= FMax) begin
          out_d.status = ST_FULL;
          state_d = S_DONE;
        end else begin
          lv_d[slot_q] = 1'b0;
          use_d = use_q - len_q;
          out_d.status = ST_OK;
          out_d.data_offset = req_q.release_offset;
          out_d.granted_size = len_q;
          out_d.bytes_in_use = use_d;
          state_d = S_DONE;
          if (adj_prev && adj_next) begin
            fwe = 1'b1; fwa = FW'(pos_q - CW'(1)); fws = ps_q;
            fwl = pl_q + LenW'(HEADER_BYTES) + len_q + LenW'(HEADER_BYTES) + nl_q;
            fcnt_d = fcnt_q - CW'(1);
            fi_d = pos_q;
            state_d = S_DROP;
          end else if (adj_prev) begin
            fwe = 1'b1; fwa = FW'(pos_q - CW'(1)); fws = ps_q;
            fwl = pl_q + LenW'(HEADER_BYTES) + len_q;
          end else if (adj_next) begin
            fwe = 1'b1; fwa = FW'(pos_q); fws = hdr_q;
            fwl = nl_q + LenW'(HEADER_BYTES) + len_q;
          end else begin
            hold_s_d = hdr_q; hold_l_d = len_q;
            fcnt_d = fcnt_q + CW'(1);
            fi_d = pos_q;
            state_d = S_INSERT;
          end
        end
      end
      S_INSERT: begin
        // Ripple: write the carried entry, carry the old one up.
        fwe = 1'b1; fwa = fidx; fws = hold_s_q; fwl = hold_l_q;
        hold_s_d = fs_r; hold_l_d = fl_r;
        fi_d = fi_q + CW'(1);
        if (fi_q + CW'(1) >= fcnt_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### test/testbench.sv
// Self-checking testbench for the first-fit extent allocator.
// Drives allocate and free transactions, predicts every response and compares fields.
// Depends on ffea_pkg and first_fit_extent_allocator.
`timescale 1ns / 100ps

module testbench;
  import ffea_pkg::*;

  localparam int unsigned WatchdogLimit = 200000;
  localparam int unsigned RandomItems   = 1200;

  typedef struct packed {
    logic  check_exact;
    req_t  req;
    rsp_t  rsp;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_data_o;

  logic [OffW-1:0] ext_start [MaxFreeExtents];
  logic [LenW-1:0] ext_len [MaxFreeExtents];
  int unsigned     ext_count;
  logic [OffW-1:0] blk_start [MaxLiveBlocks];
  logic [LenW-1:0] blk_len [MaxLiveBlocks];
  logic            blk_live [MaxLiveBlocks];
  longint unsigned sum_granted;
  longint unsigned sum_released;

  rsp_t        pending_rsp [$];
  int unsigned error_count;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        sending_done;
  row_t        rows [$];

  first_fit_extent_allocator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic void reset_pool();
    for (int i = 0; i < MaxFreeExtents; i++) begin
      ext_start[i] = '0;
      ext_len[i] = '0;
    end
    for (int i = 0; i < MaxLiveBlocks; i++) begin
      blk_live[i] = 1'b0;
    end
    ext_start[0] = '0;
    ext_len[0] = LenW'(PoolBytes - HeaderBytes);
    ext_count = 1;
    sum_granted = 0;
    sum_released = 0;
  endfunction

  function automatic void remove_extent(int unsigned pos);
    for (int unsigned i = pos; i + 1 < ext_count; i++) begin
      ext_start[i] = ext_start[i+1];
      ext_len[i] = ext_len[i+1];
    end
    ext_count--;
  endfunction

  function automatic rsp_t allocate_or_release(req_t req);
    rsp_t r;
    longint unsigned need;
    longint unsigned hdr;
    longint unsigned len;
    int unsigned pos;
    int unsigned slot;
    logic prev_adj;
    logic next_adj;
    r = '0;
    if (req.func == FUNC_ALLOC) begin
      need = (longint'(req.request_size) + Alignment - 1) & ~longint'(Alignment - 1);
      if (need < Alignment) need = Alignment;
      pos = 0;
      while (pos < ext_count && longint'(ext_len[pos]) < need) pos++;
      slot = 0;
      while (slot < MaxLiveBlocks && blk_live[slot]) slot++;
      if (pos >= ext_count) begin
        r.status = ST_NO_FIT;
      end else if (slot >= MaxLiveBlocks) begin
        r.status = ST_FULL;
      end else begin
        hdr = ext_start[pos];
        len = ext_len[pos];
        if (len >= need + HeaderBytes + Alignment) begin
          ext_start[pos] = OffW'(hdr + HeaderBytes + need);
          ext_len[pos] = LenW'(len - need - HeaderBytes);
          len = need;
        end else begin
          remove_extent(pos);
        end
        blk_live[slot] = 1'b1;
        blk_start[slot] = OffW'(hdr);
        blk_len[slot] = LenW'(len);
        sum_granted += len;
        r.status = ST_OK;
        r.data_offset = OffW'(hdr + HeaderBytes);
        r.granted_size = LenW'(len);
      end
    end else begin
      slot = 0;
      while (slot < MaxLiveBlocks &&
             !(blk_live[slot] && longint'(blk_start[slot]) + HeaderBytes ==
               longint'(req.release_offset))) slot++;
      if (slot >= MaxLiveBlocks) begin
        r.status = ST_NOT_LIVE;
      end else begin
        hdr = blk_start[slot];
        len = blk_len[slot];
        pos = 0;
        while (pos < ext_count && longint'(ext_start[pos]) <= hdr) pos++;
        next_adj = pos < ext_count && hdr + HeaderBytes + len == longint'(ext_start[pos]);
        prev_adj = pos > 0 &&
                   longint'(ext_start[pos-1]) + HeaderBytes + ext_len[pos-1] == hdr;
        if (!prev_adj && !next_adj && ext_count >= MaxFreeExtents) begin
          r.status = ST_FULL;
        end else begin
          if (prev_adj && next_adj) begin
            ext_len[pos-1] = LenW'(ext_len[pos-1] + 2 * HeaderBytes + len + ext_len[pos]);
            remove_extent(pos);
          end else if (prev_adj) begin
            ext_len[pos-1] = LenW'(ext_len[pos-1] + HeaderBytes + len);
          end else if (next_adj) begin
            ext_start[pos] = OffW'(hdr);
            ext_len[pos] = LenW'(ext_len[pos] + HeaderBytes + len);
          end else begin
            for (int unsigned i = ext_count; i > pos; i--) begin
              ext_start[i] = ext_start[i-1];
              ext_len[i] = ext_len[i-1];
            end
            ext_start[pos] = OffW'(hdr);
            ext_len[pos] = LenW'(len);
            ext_count++;
          end
          blk_live[slot] = 1'b0;
          sum_released += len;
          r.status = ST_OK;
          r.data_offset = req.release_offset;
          r.granted_size = LenW'(len);
        end
      end
    end
    r.bytes_in_use = LenW'(sum_granted - sum_released);
    return r;
  endfunction

  function automatic req_t make_req(func_e f, int unsigned sz, int unsigned off);
    req_t q;
    q.func = f;
    q.request_size = LenW'(sz);
    q.release_offset = OffW'(off);
    return q;
  endfunction

  function automatic rsp_t make_rsp(status_e s, int unsigned off, int unsigned sz,
                                    int unsigned used);
    rsp_t r;
    r.status = s;
    r.data_offset = OffW'(off);
    r.granted_size = LenW'(sz);
    r.bytes_in_use = LenW'(used);
    return r;
  endfunction

  function automatic int unsigned live_offset();
    int unsigned slot;
    int unsigned tries;
    tries = 0;
    slot = $urandom_range(MaxLiveBlocks - 1);
    while (!blk_live[slot] && tries < MaxLiveBlocks) begin
      slot = (slot + 1) % MaxLiveBlocks;
      tries++;
    end
    if (!blk_live[slot]) return $urandom_range(1048575);
    return blk_start[slot] + HeaderBytes;
  endfunction

  function automatic int unsigned live_offset_at(int unsigned slot);
    if (!blk_live[slot]) return 0;
    return blk_start[slot] + HeaderBytes;
  endfunction

  function automatic req_t random_req();
    int unsigned pick;
    int unsigned sz;
    pick = $urandom_range(99);
    if (pick < 6) sz = $urandom_range(2097151);
    else if (pick < 10) sz = $urandom_range(1048576, 1048000);
    else if (pick < 40) sz = $urandom_range(64);
    else if (pick < 80) sz = $urandom_range(4096);
    else sz = $urandom_range(65536);
    pick = $urandom_range(99);
    if (pick < 50) return make_req(FUNC_ALLOC, sz, $urandom);
    if (pick < 92) return make_req(FUNC_FREE, $urandom, live_offset());
    if (pick < 96) return make_req(FUNC_FREE, $urandom, $urandom_range(1048575));
    return make_req(FUNC_FREE, $urandom, live_offset() + 16 * $urandom_range(1, 3));
  endfunction

  task automatic send_item(input req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    pending_rsp.push_back(allocate_or_release(req));
  endtask

  // The exact rows are checked by running the predictor ahead once; this puts its
  // state back so that the row is predicted again when it is actually sent.
  task automatic reset_pool_replay(input int upto);
    reset_pool();
    for (int j = 0; j < upto; j++) void'(allocate_or_release(rows[j].req));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
    if (out_valid_o && out_ready_i) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected transaction", out_data_o, 0);
      end else begin
        if (out_data_o.status !== pending_rsp[0].status)
          report_mismatch("status", out_data_o.status, pending_rsp[0].status);
        if (out_data_o.data_offset !== pending_rsp[0].data_offset)
          report_mismatch("data_offset", out_data_o.data_offset, pending_rsp[0].data_offset);
        if (out_data_o.granted_size !== pending_rsp[0].granted_size)
          report_mismatch("granted_size", out_data_o.granted_size,
                          pending_rsp[0].granted_size);
        if (out_data_o.bytes_in_use !== pending_rsp[0].bytes_in_use)
          report_mismatch("bytes_in_use", out_data_o.bytes_in_use,
                          pending_rsp[0].bytes_in_use);
        void'(pending_rsp.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni ||
        (sending_done && pending_rsp.size() == 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rsp_t want;
    int unsigned n;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    error_count = 0;
    quiet_cycles = 0;
    sending_done = 1'b0;
    send_idle_pct = 6;
    recv_idle_pct = 52;
    reset_pool();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    rows.push_back({1'b1, make_req(FUNC_FREE, 0, 16), make_rsp(ST_NOT_LIVE, 0, 0, 0)});
    rows.push_back({1'b1, make_req(FUNC_ALLOC, 0, 0), make_rsp(ST_OK, 16, 16, 16)});
    rows.push_back({1'b1, make_req(FUNC_ALLOC, 1, 0), make_rsp(ST_OK, 48, 16, 32)});
    rows.push_back({1'b1, make_req(FUNC_ALLOC, 17, 0), make_rsp(ST_OK, 80, 32, 64)});
    rows.push_back({1'b1, make_req(FUNC_ALLOC, 2097151, 0),
                    make_rsp(ST_NO_FIT, 0, 0, 64)});
    rows.push_back({1'b1, make_req(FUNC_ALLOC, 1048576, 0),
                    make_rsp(ST_NO_FIT, 0, 0, 64)});
    rows.push_back({1'b0, make_req(FUNC_FREE, 0, 48), rsp_t'(0)});
    rows.push_back({1'b0, make_req(FUNC_FREE, 0, 48), rsp_t'(0)});
    rows.push_back({1'b0, make_req(FUNC_FREE, 0, 16), rsp_t'(0)});
    rows.push_back({1'b0, make_req(FUNC_FREE, 0, 1048575), rsp_t'(0)});
    rows.push_back({1'b0, make_req(FUNC_ALLOC, 48, 0), rsp_t'(0)});
    rows.push_back({1'b0, make_req(FUNC_ALLOC, 1048000, 0), rsp_t'(0)});
    rows.push_back({1'b0, make_req(FUNC_FREE, 0, 80), rsp_t'(0)});
    rows.push_back({1'b0, make_req(FUNC_FREE, 0, 16), rsp_t'(0)});
    rows.push_back({1'b0, make_req(FUNC_FREE, 0, 144), rsp_t'(0)});
    rows.push_back({1'b0, make_req(FUNC_ALLOC, 1048560, 0), rsp_t'(0)});
    rows.push_back({1'b0, make_req(FUNC_FREE, 2097151, 16), rsp_t'(0)});
    foreach (rows[i]) begin
      if (rows[i].check_exact) begin
        want = allocate_or_release(rows[i].req);
        if (want !== rows[i].rsp) report_mismatch("directed row", want, rows[i].rsp);
        void'(pending_rsp.size());
        reset_pool_replay(i);
      end
      send_item(rows[i].req);
    end

    // Fill the live table, then fragment the free table by freeing every even slot.
    for (int i = 0; i < 66; i++) send_item(make_req(FUNC_ALLOC, 16, 0));
    for (int i = 0; i < 64; i += 2) send_item(make_req(FUNC_FREE, 0, live_offset_at(i)));
    for (int i = 0; i < 4; i++) send_item(make_req(FUNC_ALLOC, $urandom_range(200), 0));
    for (int i = 1; i < 64; i += 2) send_item(make_req(FUNC_FREE, 0, live_offset()));

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 52 : 0;
      recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 6 : 0;
      n = 0;
      while (n < RandomItems / 3) begin
        send_item(random_req());
        n++;
      end
    end
    in_valid_i <= 1'b0;
    sending_done = 1'b1;
    wait (pending_rsp.size() == 0);
    repeat (300) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
sv/ffea_pkg.sv
sv/first_fit_extent_allocator.sv
test/testbench.sv
